/* design/bfr_pkg.sv */
package bfr_pkg;

  localparam int unsigned FIRST_CODE = 33;
  localparam int unsigned LAST_CODE  = 127;
  localparam int unsigned COUNT_BITS = 20;

  localparam int unsigned NCH    = LAST_CODE - FIRST_CODE;
  localparam int unsigned NBINS  = NCH * NCH;
  localparam int unsigned BIN_AW = $clog2(NBINS);

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned RANK_W = 14;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [COUNT_BITS:0]   span_t;
  typedef logic [BIN_AW-1:0]     bin_addr_t;
  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [RANK_W-1:0]     rank_t;
  typedef logic [BYTE_W-1:0]     byte_t;

  localparam count_t CNT_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TEXT  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

endpackage

/* design/bfr_if.sv */
interface bfr_in_if;
  import bfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  byte_t             text_byte;
  rank_t             rank;

  modport source (output valid, cmd, text_byte, rank, input ready);
  modport sink   (input valid, cmd, text_byte, rank, output ready);
endinterface

interface bfr_out_if;
  import bfr_pkg::*;

  logic   valid;
  logic   ready;
  char_t  lead_char;
  char_t  second_char;
  count_t pair_count;
  logic   found;

  modport source (output valid, lead_char, second_char, pair_count, found, input ready);
  modport sink   (input valid, lead_char, second_char, pair_count, found, output ready);
endinterface

/* design/bigram_frequency_rank.sv */
// channel  dir  payload                                          item accepted
// in_i     in   cmd, text_byte, rank                             valid && ready
// out_o    out  lead_char, second_char, pair_count, found        valid && ready
//
// text bytes stream at one item per cycle while idle: read-modify-write on the bin memory
// with forwarding of the previous write
// a rank query walks all 8836 bins once per step of a binary search on the count
// (up to 20 steps) plus one final walk that stops at the match
// a clear and the pass after reset write zero to one bin a cycle, no item taken
// meanwhile; a finished result waits in the output register
module bigram_frequency_rank (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfr_in_if.sink     in_i,
  bfr_out_if.source  out_o
);
  import bfr_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_SEARCH  = 6'b000100,
    ST_SCAN_GE = 6'b001000,
    ST_SCAN_EQ = 6'b010000,
    ST_RESULT  = 6'b100000
  } state_e;

  function automatic logic code_ok(byte_t c);
    return (c >= BYTE_W'(FIRST_CODE)) && (c < BYTE_W'(LAST_CODE));
  endfunction

  state_e    state_q;
  bin_addr_t clr_addr_q;
  byte_t     prev_q;

  logic      s1_vld_q;
  bin_addr_t s1_addr_q;
  logic      fw_vld_q;
  bin_addr_t fw_addr_q;
  count_t    fw_data_q;

  logic      sc_issue_q;
  bin_addr_t sc_addr_q;
  char_t     sc_row_q, sc_col_q;
  logic      rd_vld_q, rd_last_q;
  char_t     rd_row_q, rd_col_q;

  count_t    lo_q, hi_q, mid_q;
  rank_t     rank_q, above_q, cnt_q, need_q;
  char_t     res_first_q, res_second_q;
  count_t    res_count_q;
  logic      res_found_q;

  logic      out_vld_q;
  char_t     out_first_q, out_second_q;
  count_t    out_count_q;
  logic      out_found_q;

  logic      in_acc;
  cmd_e      cmd;
  char_t     prev_off, byte_off;
  bin_addr_t text_addr;
  logic      ram_we;
  bin_addr_t ram_waddr, ram_raddr;
  count_t    ram_wdata, ram_rdata;
  count_t    s1_cur, s1_new;
  logic      hit_ge, hit_eq;
  rank_t     cnt_next;
  span_t     span;
  count_t    mid;
  logic      sc_last, scan_start, scan_stop, res_load;

  assign in_acc   = in_i.valid && in_i.ready;
  assign cmd      = cmd_e'(in_i.cmd);
  assign in_i.ready = (state_q == ST_IDLE);

  // bin index of the pair (previous byte, new byte)
  assign prev_off  = CHAR_W'(prev_q - BYTE_W'(FIRST_CODE));
  assign byte_off  = CHAR_W'(in_i.text_byte - BYTE_W'(FIRST_CODE));
  assign text_addr = BIN_AW'(prev_off) * BIN_AW'(NCH) + BIN_AW'(byte_off);

  assign s1_cur = (fw_vld_q && (fw_addr_q == s1_addr_q)) ? fw_data_q : ram_rdata;
  assign s1_new = (s1_cur == CNT_MAX) ? s1_cur : s1_cur + count_t'(1);

  assign ram_we    = (state_q == ST_CLEAR) || s1_vld_q;
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : s1_addr_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : s1_new;
  assign ram_raddr = sc_issue_q ? sc_addr_q : text_addr;

  bfr_ram #(
    .Width (COUNT_BITS),
    .Depth (NBINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign hit_ge   = rd_vld_q && (ram_rdata >= mid_q);
  assign hit_eq   = rd_vld_q && (ram_rdata == lo_q);
  assign cnt_next = cnt_q + RANK_W'(hit_ge);
  assign span     = {1'b0, hi_q} - {1'b0, lo_q} + span_t'(1);
  assign mid      = lo_q + COUNT_BITS'(span >> 1);

  assign sc_last    = (sc_addr_q == BIN_AW'(NBINS - 1));
  assign scan_start = (state_q == ST_SEARCH);
  assign scan_stop  = (state_q == ST_SCAN_EQ) && hit_eq && (need_q == RANK_W'(1));
  assign res_load   = (state_q == ST_RESULT) && (!out_vld_q || out_o.ready);

  // text path: read in the accept cycle, update and write in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      s1_vld_q <= 1'b0;
      fw_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_acc && (cmd == CMD_TEXT) && code_ok(prev_q) && code_ok(in_i.text_byte);
      fw_vld_q <= s1_vld_q;
      if (in_acc && (cmd == CMD_TEXT)) begin
        prev_q <= in_i.text_byte;
      end else if (in_acc && (cmd == CMD_CLEAR)) begin
        prev_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= text_addr;
    fw_addr_q <= s1_addr_q;
    fw_data_q <= s1_new;
  end

  // bin walker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_issue_q <= 1'b0;
      rd_vld_q   <= 1'b0;
    end else begin
      rd_vld_q <= sc_issue_q && !scan_stop;
      if (scan_start) begin
        sc_issue_q <= 1'b1;
      end else if (scan_stop || (sc_issue_q && sc_last)) begin
        sc_issue_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_last_q <= sc_last;
    rd_row_q  <= sc_row_q;
    rd_col_q  <= sc_col_q;
    if (scan_start) begin
      sc_addr_q <= '0;
      sc_row_q  <= '0;
      sc_col_q  <= '0;
    end else if (sc_issue_q) begin
      sc_addr_q <= sc_addr_q + bin_addr_t'(1);
      if (sc_col_q == CHAR_W'(NCH - 1)) begin
        sc_col_q <= '0;
        sc_row_q <= sc_row_q + char_t'(1);
      end else begin
        sc_col_q <= sc_col_q + char_t'(1);
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_addr_q == BIN_AW'(NBINS - 1)) begin
            clr_addr_q <= '0;
            state_q    <= ST_IDLE;
          end else begin
            clr_addr_q <= clr_addr_q + bin_addr_t'(1);
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            unique case (cmd)
              CMD_QUERY: begin
                if ((in_i.rank == '0) || (in_i.rank > RANK_W'(NBINS))) begin
                  state_q <= ST_RESULT;
                end else begin
                  state_q <= ST_SEARCH;
                end
              end
              CMD_CLEAR: state_q <= ST_CLEAR;
              default: ;
            endcase
          end
        end
        ST_SEARCH: begin
          state_q <= (lo_q < hi_q) ? ST_SCAN_GE : ST_SCAN_EQ;
        end
        ST_SCAN_GE: begin
          if (rd_vld_q && rd_last_q) begin
            state_q <= ST_SEARCH;
          end
        end
        ST_SCAN_EQ: begin
          if (scan_stop || (rd_vld_q && rd_last_q)) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (res_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

  // search datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        rank_q       <= in_i.rank;
        lo_q         <= '0;
        hi_q         <= CNT_MAX;
        above_q      <= '0;
        res_first_q  <= '0;
        res_second_q <= '0;
        res_count_q  <= '0;
        res_found_q  <= 1'b0;
      end
      ST_SEARCH: begin
        mid_q  <= mid;
        cnt_q  <= '0;
        need_q <= rank_q - above_q;
      end
      ST_SCAN_GE: begin
        if (rd_vld_q) begin
          cnt_q <= cnt_next;
          if (rd_last_q) begin
            if (cnt_next >= rank_q) begin
              lo_q <= mid_q;
            end else begin
              hi_q    <= mid_q - count_t'(1);
              above_q <= cnt_next;
            end
          end
        end
      end
      ST_SCAN_EQ: begin
        if (hit_eq) begin
          if (need_q == RANK_W'(1)) begin
            res_first_q  <= char_t'(FIRST_CODE) + rd_row_q;
            res_second_q <= char_t'(FIRST_CODE) + rd_col_q;
            res_count_q  <= ram_rdata;
            res_found_q  <= 1'b1;
          end else begin
            need_q <= need_q - rank_t'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_first_q  <= res_first_q;
      out_second_q <= res_second_q;
      out_count_q  <= res_count_q;
      out_found_q  <= res_found_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.lead_char   = out_first_q;
  assign out_o.second_char = out_second_q;
  assign out_o.pair_count  = out_count_q;
  assign out_o.found       = out_found_q;

  a_no_write_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> state_q != ST_CLEAR)
    else $error("text update overlaps clear pass");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_RESULT))
    else $error("result item without finished query");

  a_need_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN_EQ |-> need_q != '0)
    else $error("final walk with nothing left to find");

  a_mid_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN_GE |-> (lo_q < mid_q) && (mid_q <= hi_q))
    else $error("search midpoint out of bounds");

endmodule

/* design/bfr_ram.sv */
module bfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
